// File: src/sdi12_three_value_response_parser_macros.svh
// ----------------------------------------------------------------------------
// sdi12 three value response parser assertion macros
// Concurrent assertion helpers shared by the parser RTL.
// ----------------------------------------------------------------------------
`ifndef SDI12_THREE_VALUE_RESPONSE_PARSER_MACROS_SVH
`define SDI12_THREE_VALUE_RESPONSE_PARSER_MACROS_SVH

`ifndef ASSERT_OFF
// same-cycle implication
`define S12TV_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("s12tv assertion failed");
// next-cycle implication
`define S12TV_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("s12tv assertion failed");
`else
`define S12TV_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define S12TV_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

// File: src/s12tv_pkg.sv
// ----------------------------------------------------------------------------
// s12tv_pkg
// Types, character codes and fixed-point helpers for the response parser.
// ----------------------------------------------------------------------------
package s12tv_pkg;

  localparam int MAX_VALUES_DEF  = 3;
  localparam int FRAC_DIGITS_DEF = 3;
  localparam int NEEDED_VALUES   = 3;

  localparam logic [2:0]  MIN_LENGTH = 3'd5;
  localparam logic [31:0] MAG_CAP    = 32'h8000_0000;
  localparam logic [31:0] POS_MAX    = 32'h7FFF_FFFF;

  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_POINT = 8'h2E;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } s12tv_item_t;

  typedef struct packed {
    logic               ok;
    logic        [30:0] water_content;
    logic signed [31:0] soil_temp;
    logic signed [31:0] conductivity;
  } s12tv_result_t;

  // powers of ten, out-of-range exponents stick at the top entry
  function automatic logic [19:0] pow10(int k);
    logic [19:0] p;
    case (k)
      0:       p = 20'd1;
      1:       p = 20'd10;
      2:       p = 20'd100;
      3:       p = 20'd1000;
      4:       p = 20'd10000;
      5:       p = 20'd100000;
      default: p = 20'd1000000;
    endcase
    return p;
  endfunction

  // magnitude saturates at 2^31
  function automatic logic [31:0] cap_mag(logic [35:0] t);
    logic [31:0] r;
    if (t > 36'(MAG_CAP)) begin
      r = MAG_CAP;
    end else begin
      r = t[31:0];
    end
    return r;
  endfunction

  // signed value from sign flag and magnitude
  function automatic logic [31:0] close_val(logic neg, logic [31:0] mag);
    logic [31:0] r;
    if (neg) begin
      r = 32'd0 - mag;
    end else if (mag > POS_MAX) begin
      r = POS_MAX;
    end else begin
      r = mag;
    end
    return r;
  endfunction

endpackage

// File: src/s12tv_in_reg.sv
// ----------------------------------------------------------------------------
// s12tv_in_reg
// Input register stage holding one received byte and its last flag.
// ----------------------------------------------------------------------------
module s12tv_in_reg (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  s12tv_pkg::s12tv_item_t item_i,
  input  logic                  consume_i,
  output logic                  item_valid_o,
  output s12tv_pkg::s12tv_item_t item_o
);
  import s12tv_pkg::*;

  logic        vld_q, vld_d;
  s12tv_item_t item_q;

  // stage frees up when empty or when its byte is consumed this cycle
  assign in_ready_o = !vld_q || consume_i;
  assign vld_d      = in_ready_o ? in_valid_i : vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      item_q <= item_i;
    end
  end

  assign item_valid_o = vld_q;
  assign item_o       = item_q;

endmodule

// File: src/s12tv_parser.sv
// ----------------------------------------------------------------------------
// s12tv_parser
// Parse state, value accumulation and result formation, one byte a cycle while fire_i is high.
// ----------------------------------------------------------------------------
module s12tv_parser #(
  parameter int MAX_VALUES  = s12tv_pkg::MAX_VALUES_DEF,
  parameter int FRAC_DIGITS = s12tv_pkg::FRAC_DIGITS_DEF
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    fire_i,
  input  s12tv_pkg::s12tv_item_t  item_i,
  output logic                    res_valid_o,
  output s12tv_pkg::s12tv_result_t res_o
);
  import s12tv_pkg::*;

  localparam int VCW = $clog2(MAX_VALUES + 1);
  localparam int IW  = (MAX_VALUES > 1) ? $clog2(MAX_VALUES) : 1;
  localparam int FW  = (FRAC_DIGITS > 0) ? $clog2(FRAC_DIGITS + 1) : 1;

  logic [2:0]     bc_q, bc_d;
  logic [VCW-1:0] vc_q, vc_d, vc_fin;
  logic           inv_q, inv_d;
  logic           halt_q, halt_d;
  logic           neg_q, neg_d;
  logic           pt_q, pt_d;
  logic [FW-1:0]  frac_q, frac_d;
  logic [31:0]    acc_q, acc_d;
  logic [31:0]    vals_q [MAX_VALUES];
  logic [31:0]    vals_d [MAX_VALUES];
  logic [2:0]     bc_fin;

  logic           is_sign, is_eol, is_digit;
  logic [3:0]     digit;
  logic [23:0]    int_term, frac_term;
  logic [35:0]    int_sum, frac_sum;
  logic [31:0]    close_v;
  logic           ok_c;
  logic [31:0]    v0, v1, v2;

  assign is_sign  = (item_i.ch == CH_PLUS) || (item_i.ch == CH_MINUS);
  assign is_eol   = (item_i.ch == CH_CR) || (item_i.ch == CH_LF);
  assign is_digit = (item_i.ch >= CH_ZERO) && (item_i.ch <= CH_NINE);
  assign digit    = item_i.ch[3:0];

  // integer digit: acc * 10 + d * 10^F
  assign int_term  = 24'(digit) * 24'(pow10(FRAC_DIGITS));
  assign int_sum   = (36'(acc_q) << 3) + (36'(acc_q) << 1) + 36'(int_term);
  // fractional digit: acc + d * 10^(F-1-frac)
  assign frac_term = 24'(digit) * 24'(pow10(FRAC_DIGITS - 1 - int'(frac_q)));
  assign frac_sum  = 36'(acc_q) + 36'(frac_term);

  assign close_v = close_val(neg_q, acc_q);

  always_comb begin
    bc_d   = bc_q;
    vc_d   = vc_q;
    inv_d  = inv_q;
    halt_d = halt_q;
    neg_d  = neg_q;
    pt_d   = pt_q;
    frac_d = frac_q;
    acc_d  = acc_q;
    vals_d = vals_q;
    vc_fin = vc_q;
    bc_fin = bc_q;
    ok_c   = 1'b0;
    if (fire_i) begin
      if (bc_q < MIN_LENGTH) begin
        bc_d = bc_q + 3'd1;
      end
      // address byte is skipped
      if (bc_q != 3'd0) begin
        if (is_sign) begin
          if (inv_q) begin
            if (32'(vc_q) < MAX_VALUES) begin
              vals_d[vc_q[IW-1:0]] = close_v;
              vc_d = vc_q + VCW'(1);
            end
            inv_d = 1'b0;
          end
          if (32'(vc_d) < MAX_VALUES) begin
            inv_d  = 1'b1;
            neg_d  = (item_i.ch == CH_MINUS);
            halt_d = 1'b0;
            pt_d   = 1'b0;
            frac_d = '0;
            acc_d  = '0;
          end
        end else if (is_eol) begin
          if (inv_q) begin
            if (32'(vc_q) < MAX_VALUES) begin
              vals_d[vc_q[IW-1:0]] = close_v;
              vc_d = vc_q + VCW'(1);
            end
            inv_d = 1'b0;
          end
        end else if (inv_q && !halt_q) begin
          if (is_digit) begin
            if (!pt_q) begin
              acc_d = cap_mag(int_sum);
            end else if (32'(frac_q) < FRAC_DIGITS) begin
              acc_d  = cap_mag(frac_sum);
              frac_d = frac_q + FW'(1);
            end
          end else if ((item_i.ch == CH_POINT) && !pt_q) begin
            pt_d = 1'b1;
          end else begin
            halt_d = 1'b1;
          end
        end
      end
      if (item_i.last) begin
        // an open value is closed at the end of the reply
        vc_fin = vc_d;
        if (inv_d && (32'(vc_d) < MAX_VALUES)) begin
          vals_d[vc_d[IW-1:0]] = close_val(neg_d, acc_d);
          vc_fin = vc_d + VCW'(1);
        end
        bc_fin = bc_d;
        ok_c   = (MAX_VALUES >= NEEDED_VALUES) && (bc_fin >= MIN_LENGTH) &&
                 (32'(vc_fin) >= NEEDED_VALUES);
        bc_d   = '0;
        vc_d   = '0;
        inv_d  = 1'b0;
        halt_d = 1'b0;
        neg_d  = 1'b0;
        pt_d   = 1'b0;
        frac_d = '0;
        acc_d  = '0;
      end
    end
  end

  assign v0 = vals_d[0];

  if (MAX_VALUES > 1) begin : g_v1
    assign v1 = vals_d[1];
  end else begin : g_no_v1
    assign v1 = '0;
  end

  if (MAX_VALUES > 2) begin : g_v2
    assign v2 = vals_d[2];
  end else begin : g_no_v2
    assign v2 = '0;
  end

  assign res_valid_o         = fire_i && item_i.last;
  assign res_o.ok            = ok_c;
  assign res_o.water_content = (ok_c && !v0[31]) ? v0[30:0] : 31'd0;
  assign res_o.soil_temp     = ok_c ? v1 : 32'sd0;
  assign res_o.conductivity  = ok_c ? v2 : 32'sd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bc_q   <= '0;
      vc_q   <= '0;
      inv_q  <= 1'b0;
      halt_q <= 1'b0;
      neg_q  <= 1'b0;
      pt_q   <= 1'b0;
      frac_q <= '0;
      acc_q  <= '0;
    end else begin
      bc_q   <= bc_d;
      vc_q   <= vc_d;
      inv_q  <= inv_d;
      halt_q <= halt_d;
      neg_q  <= neg_d;
      pt_q   <= pt_d;
      frac_q <= frac_d;
      acc_q  <= acc_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < MAX_VALUES; i++) begin
        vals_q[i] <= '0;
      end
    end else begin
      vals_q <= vals_d;
    end
  end

endmodule

// File: src/s12tv_out_reg.sv
// ----------------------------------------------------------------------------
// s12tv_out_reg
// Result register holding one parsed reply until the receiver takes it.
// ----------------------------------------------------------------------------
module s12tv_out_reg (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     res_valid_i,
  input  s12tv_pkg::s12tv_result_t res_i,
  output logic                     can_load_o,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output s12tv_pkg::s12tv_result_t res_o
);
  import s12tv_pkg::*;

  logic          vld_q, vld_d;
  s12tv_result_t res_q;

  // register is free when empty or being drained this cycle
  assign can_load_o = !vld_q || out_ready_i;
  assign vld_d      = can_load_o ? res_valid_i : vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid_i && can_load_o) begin
      res_q <= res_i;
    end
  end

  assign out_valid_o = vld_q;
  assign res_o       = res_q;

endmodule

// File: src/sdi12_three_value_response_parser.sv
// ----------------------------------------------------------------------------
// sdi12_three_value_response_parser
// Streams a sensor data reply byte by byte and returns its first three values.
// ----------------------------------------------------------------------------
// Input channel: in_valid_i / in_ready_o carry one ASCII byte (ch_i) per
// transaction, with last_i set on the final byte of a reply. Byte 0 is the
// address and skipped; each sign starts a fixed-point value, up to MAX_VALUES.
// Output channel: out_valid_o / out_ready_i carry one result per reply:
// ok_o, water_content_o, soil_temp_o and conductivity_o.
// Throughput: one byte per cycle, but for stalls on a final byte. A byte is
// registered on acceptance and folded into the parse state when the input
// register releases it; the result register loads on that same edge, so
// out_valid_o follows the input register and then the result register.
// Stall: non-final bytes keep flowing while a result waits. A final byte is
// held in the input register until the result register is free, and the
// input stalls behind it.
// Reset: asynchronous, active low; parse state, byte and value counts clear
// and both channels come up empty. Parse state also returns to reset after
// each final byte.
// ----------------------------------------------------------------------------
`include "sdi12_three_value_response_parser_macros.svh"

module sdi12_three_value_response_parser #(
  parameter int MAX_VALUES  = s12tv_pkg::MAX_VALUES_DEF,
  parameter int FRAC_DIGITS = s12tv_pkg::FRAC_DIGITS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic        [7:0]  ch_i,
  input  logic               last_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic               ok_o,
  output logic        [30:0] water_content_o,
  output logic signed [31:0] soil_temp_o,
  output logic signed [31:0] conductivity_o
);
  import s12tv_pkg::*;

  s12tv_item_t   in_item, item;
  logic          item_vld;
  logic          fire;
  logic          can_load;
  logic          res_vld;
  s12tv_result_t res, res_out;

  assign in_item.ch   = ch_i;
  assign in_item.last = last_i;

  // a final byte needs room in the result register
  assign fire = item_vld && (!item.last || can_load);

  s12tv_in_reg u_in_reg (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .item_i       (in_item),
    .consume_i    (fire),
    .item_valid_o (item_vld),
    .item_o       (item)
  );

  s12tv_parser #(
    .MAX_VALUES  (MAX_VALUES),
    .FRAC_DIGITS (FRAC_DIGITS)
  ) u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .fire_i      (fire),
    .item_i      (item),
    .res_valid_o (res_vld),
    .res_o       (res)
  );

  s12tv_out_reg u_out_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .res_valid_i (res_vld),
    .res_i       (res),
    .can_load_o  (can_load),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .res_o       (res_out)
  );

  assign ok_o            = res_out.ok;
  assign water_content_o = res_out.water_content;
  assign soil_temp_o     = res_out.soil_temp;
  assign conductivity_o  = res_out.conductivity;

  `S12TV_ASSERT_IMPL(a_fail_zero, clk_i, rst_ni, out_valid_o && !ok_o, (water_content_o == 31'd0) && (soil_temp_o == 32'sd0) && (conductivity_o == 32'sd0))
  `S12TV_ASSERT_IMPL(a_stall_cause, clk_i, rst_ni, !in_ready_o, item_vld && item.last && out_valid_o && !out_ready_i)
  `S12TV_ASSERT_NEXT(a_last_gives_result, clk_i, rst_ni, fire && item.last, out_valid_o)

endmodule

// File: tb/sdi12_reply_checker.sv
// ----------------------------------------------------------------------------
// sdi12 reply checker
// Watches both channels of the response parser, folds every accepted byte
// into its own copy of the parse state and compares each result with the
// oldest outstanding prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sdi12_reply_checker (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_ready_i,
  input  logic        [7:0]  ch_i,
  input  logic               last_i,
  input  logic               out_valid_i,
  input  logic               out_ready_i,
  input  logic               ok_i,
  input  logic        [30:0] water_content_i,
  input  logic signed [31:0] soil_temp_i,
  input  logic signed [31:0] conductivity_i,
  output int                 pending_o,
  output int                 fail_count_o
);
  import s12tv_pkg::*;

  localparam int MAX_FIELDS = MAX_VALUES_DEF;
  localparam int FRAC       = FRAC_DIGITS_DEF;

  // parse state of the reply in flight
  logic [2:0]  rx_pos;
  int          fields_taken;
  logic        field_open;
  logic        field_halted;
  logic        field_neg;
  logic        field_point;
  int          frac_seen;
  logic [31:0] mag_acc;
  logic [31:0] field_vals [MAX_FIELDS];

  s12tv_result_t pending_results [$];
  int            errors = 0;

  initial begin
    pending_o    = 0;
    fail_count_o = 0;
  end

  function automatic logic [31:0] ten_pow(int k);
    logic [31:0] p;
    p = 32'd1;
    for (int i = 0; i < k && i < 6; i++) begin
      p = p * 32'd10;
    end
    return p;
  endfunction

  task automatic clear_parse();
    rx_pos       = '0;
    fields_taken = 0;
    field_open   = 1'b0;
    field_halted = 1'b0;
    field_neg    = 1'b0;
    field_point  = 1'b0;
    frac_seen    = 0;
    mag_acc      = '0;
    for (int i = 0; i < MAX_FIELDS; i++) begin
      field_vals[i] = '0;
    end
  endtask

  task automatic finish_field();
    logic [31:0] v;
    if (field_neg) begin
      v = 32'd0 - mag_acc;
    end else begin
      v = (mag_acc > POS_MAX) ? POS_MAX : mag_acc;
    end
    if (fields_taken < MAX_FIELDS) begin
      field_vals[fields_taken] = v;
      fields_taken++;
    end
    field_open = 1'b0;
  endtask

  task automatic predict_byte(input logic [7:0] c, input logic fin);
    logic [2:0]    pos;
    logic [31:0]   digit;
    logic [63:0]   sum;
    logic [31:0]   first;
    s12tv_result_t res;
    pos   = rx_pos;
    digit = 32'(c) - 32'(CH_ZERO);
    if (rx_pos < MIN_LENGTH) begin
      rx_pos = rx_pos + 3'd1;
    end
    // the address byte never reaches the number parser
    if (pos != 3'd0) begin
      if (c == CH_PLUS || c == CH_MINUS) begin
        if (field_open) begin
          finish_field();
        end
        if (fields_taken < MAX_FIELDS) begin
          field_open   = 1'b1;
          field_neg    = (c == CH_MINUS);
          field_halted = 1'b0;
          field_point  = 1'b0;
          frac_seen    = 0;
          mag_acc      = '0;
        end
      end else if (c == CH_CR || c == CH_LF) begin
        if (field_open) begin
          finish_field();
        end
      end else if (field_open && !field_halted) begin
        if (c >= CH_ZERO && c <= CH_NINE) begin
          if (!field_point) begin
            sum = 64'(mag_acc) * 64'd10 + 64'(digit) * 64'(ten_pow(FRAC));
            mag_acc = (sum > 64'(MAG_CAP)) ? MAG_CAP : sum[31:0];
          end else if (frac_seen < FRAC) begin
            sum = 64'(mag_acc) + 64'(digit) * 64'(ten_pow(FRAC - 1 - frac_seen));
            mag_acc = (sum > 64'(MAG_CAP)) ? MAG_CAP : sum[31:0];
            frac_seen++;
          end
        end else if (c == CH_POINT && !field_point) begin
          field_point = 1'b1;
        end else begin
          field_halted = 1'b1;
        end
      end
    end
    if (fin) begin
      if (field_open) begin
        finish_field();
      end
      res = '0;
      if (rx_pos >= MIN_LENGTH && fields_taken >= NEEDED_VALUES) begin
        first             = field_vals[0];
        res.ok            = 1'b1;
        res.water_content = first[31] ? 31'd0 : first[30:0];
        res.soil_temp     = field_vals[1];
        res.conductivity  = field_vals[2];
      end
      pending_results.push_back(res);
      clear_parse();
    end
  endtask

  always @(posedge clk_i) begin : monitor
    s12tv_result_t want;
    if (!rst_ni) begin
      clear_parse();
      pending_results.delete();
    end else begin
      if (in_valid_i && in_ready_i) begin
        predict_byte(ch_i, last_i);
      end
      if (out_valid_i && out_ready_i) begin
        if (pending_results.size() == 0) begin
          $error("result transaction with no reply outstanding");
          errors++;
        end else begin
          want = pending_results.pop_front();
          if (ok_i !== want.ok) begin
            $error("ok expected %0d got %0d", want.ok, ok_i);
            errors++;
          end
          if (water_content_i !== want.water_content) begin
            $error("water_content expected %0d got %0d", want.water_content,
                   water_content_i);
            errors++;
          end
          if (soil_temp_i !== want.soil_temp) begin
            $error("soil_temp expected %0d got %0d", $signed(want.soil_temp),
                   soil_temp_i);
            errors++;
          end
          if (conductivity_i !== want.conductivity) begin
            $error("conductivity expected %0d got %0d", $signed(want.conductivity),
                   conductivity_i);
            errors++;
          end
        end
      end
    end
    pending_o    <= pending_results.size();
    fail_count_o <= errors;
  end

endmodule

// File: tb/testbench.sv
// ----------------------------------------------------------------------------
// sdi12 response parser testbench
// Feeds directed and random sensor replies byte by byte with random gaps and
// output stalls; the checker predicts every result and counts mismatches.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
  import s12tv_pkg::*;

  localparam int RANDOM_BYTES   = 1550;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int TAIL_CYCLES    = 10;

  logic               clk;
  logic               rst_n     = 1'b0;
  logic               in_valid  = 1'b0;
  logic               in_ready;
  logic        [7:0]  ch        = 8'd0;
  logic               last      = 1'b0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic               ok;
  logic        [30:0] water_content;
  logic signed [31:0] soil_temp;
  logic signed [31:0] conductivity;
  int                 pending;
  int                 fail_count;

  logic [7:0] reply_bytes [$];
  int         sent_bytes = 0;
  int         idle_cycles = 0;
  int         stall_left = 0;
  int         calm_left = 0;

  sdi12_three_value_response_parser dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .in_valid_i      (in_valid),
    .in_ready_o      (in_ready),
    .ch_i            (ch),
    .last_i          (last),
    .out_valid_o     (out_valid),
    .out_ready_i     (out_ready),
    .ok_o            (ok),
    .water_content_o (water_content),
    .soil_temp_o     (soil_temp),
    .conductivity_o  (conductivity)
  );

  sdi12_reply_checker checker_i (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .in_valid_i      (in_valid),
    .in_ready_i      (in_ready),
    .ch_i            (ch),
    .last_i          (last),
    .out_valid_i     (out_valid),
    .out_ready_i     (out_ready),
    .ok_i            (ok),
    .water_content_i (water_content),
    .soil_temp_i     (soil_temp),
    .conductivity_i  (conductivity),
    .pending_o       (pending),
    .fail_count_o    (fail_count)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // result side back-pressure, with calm stretches of full throughput
  always @(posedge clk) begin : ready_gen
    int roll;
    roll = $urandom_range(0, 99);
    if (calm_left > 0) begin
      calm_left <= calm_left - 1;
      out_ready <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ready  <= 1'b0;
    end else begin
      out_ready <= 1'b1;
      if (roll < 20) begin
        stall_left <= $urandom_range(1, 3);
      end else if (roll < 23) begin
        stall_left <= $urandom_range(10, 40);
      end else if (roll < 25) begin
        calm_left <= $urandom_range(50, 200);
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  task automatic load_text(input string s);
    reply_bytes.delete();
    for (int i = 0; i < s.len(); i++) begin
      reply_bytes.push_back(s[i]);
    end
  endtask

  // one reply: mostly well formed, some noise, some cut short
  task automatic compose_reply();
    int    kind;
    int    nvals;
    int    ndig;
    int    roll;
    string body;
    reply_bytes.delete();
    kind = $urandom_range(0, 99);
    if (kind < 12) begin
      repeat ($urandom_range(1, 12)) reply_bytes.push_back(8'($urandom));
    end else begin
      if ($urandom_range(0, 4) == 0) begin
        reply_bytes.push_back(8'($urandom));
      end else begin
        reply_bytes.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
      end
      nvals = ($urandom_range(0, 4) != 0) ? 3 : $urandom_range(0, 5);
      for (int v = 0; v < nvals; v++) begin
        reply_bytes.push_back($urandom_range(0, 1) ? CH_MINUS : CH_PLUS);
        if ($urandom_range(0, 29) == 0) begin
          // right at the saturation boundary
          body = $urandom_range(0, 1) ? "2147483.648" : "2147483.647";
          for (int i = 0; i < body.len(); i++) begin
            reply_bytes.push_back(body[i]);
          end
        end else begin
          roll = $urandom_range(0, 99);
          ndig = (roll < 10) ? 0 : (roll < 85) ? $urandom_range(1, 3) : $urandom_range(4, 10);
          repeat (ndig) reply_bytes.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
          if ($urandom_range(0, 2) == 0) begin
            reply_bytes.push_back(CH_POINT);
            repeat ($urandom_range(0, 5)) reply_bytes.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
          end
          if ($urandom_range(0, 9) == 0) begin
            case ($urandom_range(0, 3))
              0:       reply_bytes.push_back(CH_POINT);
              1:       reply_bytes.push_back("e");
              2:       reply_bytes.push_back(" ");
              default: reply_bytes.push_back(8'($urandom));
            endcase
            if ($urandom_range(0, 1) == 0) begin
              reply_bytes.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
            end
          end
        end
        if ($urandom_range(0, 3) == 0) begin
          reply_bytes.push_back($urandom_range(0, 1) ? CH_CR : CH_LF);
        end
      end
      if ($urandom_range(0, 2) == 0) begin
        reply_bytes.push_back(CH_CR);
        reply_bytes.push_back(CH_LF);
      end
      if (kind < 20 && reply_bytes.size() > 1) begin
        repeat ($urandom_range(1, reply_bytes.size() - 1)) void'(reply_bytes.pop_back());
      end
    end
  endtask

  task automatic send_reply(input bit calm);
    int gap;
    int roll;
    for (int i = 0; i < reply_bytes.size(); i++) begin
      gap = 0;
      if (!calm) begin
        roll = $urandom_range(0, 99);
        if (roll >= 95) begin
          gap = $urandom_range(8, 40);
        end else if (roll >= 70) begin
          gap = $urandom_range(1, 3);
        end
      end
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      in_valid <= 1'b1;
      ch       <= reply_bytes[i];
      last     <= (i == reply_bytes.size() - 1);
      do @(posedge clk); while (!in_ready);
      sent_bytes++;
    end
  endtask

  // stop sending until every outstanding result has come back
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  initial begin : stimulus
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // short reply, empty values, sign on the final byte
    load_text("0+-+");
    send_reply(1'b0);
    // saturation both ways, truncated decimals, halt, sign past the limit
    load_text("1+9999999-99999999+.1239z-");
    send_reply(1'b0);
    // sign as address, negative first value, lf separator, second point
    load_text("+-5\n+1.2.3+7");
    send_reply(1'b1);
    drain();

    sent_bytes = 0;
    while (sent_bytes < RANDOM_BYTES) begin
      compose_reply();
      send_reply($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 7) == 0) begin
        drain();
      end
    end

    drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// File: files.f
+incdir+src
src/s12tv_pkg.sv
src/s12tv_in_reg.sv
src/s12tv_parser.sv
src/s12tv_out_reg.sv
src/sdi12_three_value_response_parser.sv
tb/sdi12_reply_checker.sv
tb/testbench.sv
